>>> hdl/sapg_pkg.sv
`timescale 1ns / 1ps
package sapg_pkg;
	localparam logic [2:0] FUNC_TICK = 3'd0;
	localparam logic [2:0] FUNC_REL  = 3'd1;
	localparam logic [2:0] FUNC_ABS  = 3'd2;
	localparam logic [2:0] FUNC_VEL  = 3'd3;
	localparam logic [2:0] FUNC_SET  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic [2:0] REG_BASE   = 3'd0;
	localparam logic [2:0] REG_CRUISE = 3'd1;
	localparam logic [2:0] REG_SLOW   = 3'd2;
	localparam logic [2:0] REG_THRESH = 3'd3;
	localparam logic [2:0] REG_SPR    = 3'd4;

	localparam logic [31:0] VEL_NUM = 32'd256000000;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] step_arg;
		logic [15:0] speed_q8;
	} in_word_t;

	typedef struct packed {
		logic        step_level;
		logic        dir_level;
		logic [31:0] position;
		logic        busy_res;
		logic [1:0]  status;
	} out_word_t;

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_DIV  = 3'b010,
		U_SQRT = 3'b100
	} unit_state_t;
endpackage

>>> hdl/sapg_stream_if.sv
`timescale 1ns / 1ps
interface sapg_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sapg_divsqrt.sv
`timescale 1ns / 1ps
// bit-serial restoring divide (64/33) optionally followed by bit-serial isqrt
module sapg_divsqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        do_sqrt,
	input  logic [63:0] dividend,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [63:0] result
);
	sapg_pkg::unit_state_t state_q;
	logic [63:0] quo_q;
	logic [33:0] rem_q;
	logic [5:0]  cnt_q;
	logic        sq_q;
	logic [63:0] rad_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic [33:0] rem_sh, rem_sub, srem_sh, trial;

	assign rem_sh  = {rem_q[32:0], quo_q[63]};
	assign rem_sub = rem_sh - {1'b0, divisor};
	assign srem_sh = {srem_q[31:0], rad_q[63:62]};
	assign trial   = {root_q, 2'b01};
	assign result = sq_q ? {32'd0, root_q} : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sapg_pkg::U_IDLE;
			done <= 1'b0;
			cnt_q <= '0;
			sq_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				sapg_pkg::U_IDLE: begin
					if (start) begin
						quo_q <= dividend;
						rem_q <= '0;
						cnt_q <= '0;
						sq_q <= do_sqrt;
						state_q <= sapg_pkg::U_DIV;
					end
				end
				sapg_pkg::U_DIV: begin
					if (!rem_sub[33]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						cnt_q <= '0;
						if (sq_q) begin
							state_q <= sapg_pkg::U_SQRT;
							rad_q <= {quo_q[62:0], ~rem_sub[33]};
							srem_q <= '0;
							root_q <= '0;
						end else begin
							state_q <= sapg_pkg::U_IDLE;
							done <= 1'b1;
						end
					end
				end
				sapg_pkg::U_SQRT: begin
					rad_q <= {rad_q[61:0], 2'b00};
					if (srem_sh >= trial) begin
						srem_q <= srem_sh - trial;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						root_q <= {root_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= sapg_pkg::U_IDLE;
						done <= 1'b1;
					end
				end
				default: state_q <= sapg_pkg::U_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/stepper_accel_pulse_generator_top.sv
`timescale 1ns / 1ps
// channel | dir | word
// in      | sink   | func, step_arg, speed_q8
// out     | source | step_level, dir_level, position, busy_res, status
// cfg     | APB    | 5 registers at 4*i
// One word per input word. Ticks and other words: result valid the cycle
// after accept; the next word is accepted only once that result has been taken.
// A ramp step start runs a serial divide then a serial square root, and a
// velocity command runs the divide alone; the result is registered when it ends.
// arst_n clears all control state and loads register defaults.
// Input is held off while a result waits or the divider runs.
module stepper_accel_pulse_generator_top #(
	parameter int DELAY_WIDTH = 24,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	sapg_stream_if.sink   in_ch,
	sapg_stream_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [31:0] DMAX = 32'((64'd1 << DELAY_WIDTH) - 64'd1);
	localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [23:0] base_q, cruise_q, slow_q;
	logic [15:0] thresh_q, spr_q;

	logic [31:0] pos_q, len_q, idx_q;
	logic [DELAY_WIDTH-1:0] ticks_q, sdelay_q;
	logic pulse_q, rev_q, moving_q, const_q;

	logic busy_q;
	logic out_v_q;
	sapg_pkg::out_word_t out_q;
	logic [1:0] stat_q;

	logic du_start, du_sqrt, du_done;
	logic [63:0] du_dvd, du_res;
	logic [32:0] du_dvs;

	assign pready = 1'b1;
	always_comb begin
		case (paddr[4:2])
			sapg_pkg::REG_BASE:   prdata = {8'd0, base_q};
			sapg_pkg::REG_CRUISE: prdata = {8'd0, cruise_q};
			sapg_pkg::REG_SLOW:   prdata = {8'd0, slow_q};
			sapg_pkg::REG_THRESH: prdata = {16'd0, thresh_q};
			sapg_pkg::REG_SPR:    prdata = {16'd0, spr_q};
			default:              prdata = '0;
		endcase
	end

	function automatic logic [DELAY_WIDTH-1:0] fit(input logic [63:0] d);
		logic [63:0] t;
		t = (d > {32'd0, DMAX}) ? {32'd0, DMAX} : d;
		if (t == 64'd0) t = 64'd1;
		return t[DELAY_WIDTH-1:0];
	endfunction

	sapg_pkg::in_word_t iw;
	assign iw = in_ch.data;
	assign in_ch.ready = !busy_q && !out_v_q;
	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	logic [31:0] narg, alen;
	logic nrev;
	assign narg = (iw.func == sapg_pkg::FUNC_ABS) ? iw.step_arg - pos_q : iw.step_arg;
	assign nrev = narg[31];
	assign alen = nrev ? 32'd0 - narg : narg;
	logic [31:0] clen;
	assign clen = (alen > CMAX) ? CMAX : alen;
	logic [63:0] rd;
	assign rd = (du_res < {40'd0, cruise_q}) ? {40'd0, cruise_q} : du_res;
	logic [47:0] bsq;
	assign bsq = {24'd0, base_q} * {24'd0, base_q};

	sapg_divsqrt u_ds (
		.clk(clk), .arst_n(arst_n), .start(du_start), .do_sqrt(du_sqrt),
		.dividend(du_dvd), .divisor(du_dvs), .done(du_done), .result(du_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 24'd111803; cruise_q <= 24'd5000; slow_q <= 24'd50000;
			thresh_q <= 16'd10; spr_q <= 16'd200;
			pos_q <= '0; len_q <= '0; idx_q <= '0; ticks_q <= '0; sdelay_q <= '0;
			pulse_q <= 1'b0; rev_q <= 1'b0; moving_q <= 1'b0; const_q <= 1'b0;
			busy_q <= 1'b0; out_v_q <= 1'b0; stat_q <= sapg_pkg::ST_OK;
			du_start <= 1'b0; du_sqrt <= 1'b0;
			du_dvd <= '0; du_dvs <= '0; out_q <= '0;
		end else begin
			du_start <= 1'b0;
			if (psel && penable && pwrite) begin
				case (paddr[4:2])
					sapg_pkg::REG_BASE:   base_q <= pwdata[23:0];
					sapg_pkg::REG_CRUISE: cruise_q <= pwdata[23:0];
					sapg_pkg::REG_SLOW:   slow_q <= pwdata[23:0];
					sapg_pkg::REG_THRESH: thresh_q <= pwdata[15:0];
					sapg_pkg::REG_SPR:    spr_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			if (busy_q && du_done) begin
				if (du_sqrt) begin
					ticks_q <= fit(rd);
					sdelay_q <= fit(rd);
				end else begin
					ticks_q <= fit(du_res);
					sdelay_q <= fit(du_res);
				end
				busy_q <= 1'b0;
				out_v_q <= 1'b1;
				out_q <= '{1'b1, rev_q, pos_q, 1'b1, stat_q};
			end
			if (acc) begin
				logic fin;
				logic ramp;
				sapg_pkg::out_word_t ow;
				fin = 1'b1;
				ramp = 1'b0;
				ow.step_level = pulse_q;
				ow.dir_level = rev_q;
				ow.position = pos_q;
				ow.busy_res = moving_q;
				ow.status = sapg_pkg::ST_OK;
				stat_q <= sapg_pkg::ST_OK;
				case (iw.func)
					sapg_pkg::FUNC_TICK: begin
						if (moving_q) begin
							if (pulse_q) begin
								if (ticks_q <= DELAY_WIDTH'(1)) begin
									ticks_q <= '0;
									pulse_q <= 1'b0;
									pos_q <= rev_q ? pos_q - 32'd1 : pos_q + 32'd1;
									out_q <= '{1'b0, rev_q, rev_q ? pos_q - 32'd1 : pos_q + 32'd1,
										1'b1, sapg_pkg::ST_OK};
									fin = 1'b0;
									out_v_q <= 1'b1;
								end else ticks_q <= ticks_q - DELAY_WIDTH'(1);
							end else begin
								idx_q <= idx_q + 32'd1;
								if (idx_q + 32'd1 >= len_q) moving_q <= 1'b0;
								else begin
									pulse_q <= 1'b1;
									if (const_q) ticks_q <= sdelay_q;
									else ramp = 1'b1;
								end
							end
						end
					end
					sapg_pkg::FUNC_REL, sapg_pkg::FUNC_ABS, sapg_pkg::FUNC_VEL,
					sapg_pkg::FUNC_SET: begin
						if (moving_q) stat_q <= sapg_pkg::ST_BUSY;
						else if (iw.func == sapg_pkg::FUNC_SET) pos_q <= iw.step_arg;
						else if (iw.func == sapg_pkg::FUNC_VEL && (iw.speed_q8 == 16'd0 ||
								spr_q == 16'd0)) stat_q <= sapg_pkg::ST_ZERO;
						else if (narg != 32'd0) begin
							len_q <= clen; idx_q <= '0; rev_q <= nrev; moving_q <= 1'b1;
							pulse_q <= 1'b1;
							if (iw.func == sapg_pkg::FUNC_VEL) begin
								const_q <= 1'b1;
								busy_q <= 1'b1; fin = 1'b0;
								du_start <= 1'b1; du_sqrt <= 1'b0;
								du_dvd <= {32'd0, sapg_pkg::VEL_NUM};
								du_dvs <= {1'b0, 32'(iw.speed_q8) * 32'(spr_q)};
							end else if (alen < {16'd0, thresh_q}) begin
								const_q <= 1'b1;
								sdelay_q <= fit({40'd0, slow_q});
								ticks_q <= fit({40'd0, slow_q});
							end else begin
								// first step: j = 0
								const_q <= 1'b0;
								busy_q <= 1'b1; fin = 1'b0;
								du_start <= 1'b1; du_sqrt <= 1'b1;
								du_dvd <= {16'd0, bsq};
								du_dvs <= 33'd1;
							end
						end
					end
					default: ;
				endcase
				if (ramp) begin
					busy_q <= 1'b1; fin = 1'b0;
					du_start <= 1'b1; du_sqrt <= 1'b1;
					du_dvd <= {16'd0, bsq};
					du_dvs <= {1'b0, (idx_q + 32'd1 < len_q - 32'd1 - (idx_q + 32'd1)) ?
						idx_q + 32'd1 : len_q - 32'd2 - idx_q} + 33'd1;
				end
				if (fin) begin
					if ((iw.func != sapg_pkg::FUNC_TICK) &&
							(iw.func <= sapg_pkg::FUNC_SET)) begin
						if (moving_q) ow.status = sapg_pkg::ST_BUSY;
						else if (iw.func == sapg_pkg::FUNC_SET) ow.position = iw.step_arg;
						else if (iw.func == sapg_pkg::FUNC_VEL) begin
							if (iw.speed_q8 == 16'd0 || spr_q == 16'd0)
								ow.status = sapg_pkg::ST_ZERO;
						end else if (narg != 32'd0) begin
							ow.step_level = 1'b1; ow.dir_level = nrev;
							ow.busy_res = 1'b1;
						end
					end else if (iw.func == sapg_pkg::FUNC_TICK && moving_q) begin
						if (pulse_q) ow.step_level = 1'b1;
						else if (idx_q + 32'd1 >= len_q) ow.busy_res = 1'b0;
						else ow.step_level = 1'b1;
					end
					out_v_q <= 1'b1;
					out_q <= ow;
				end
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
endmodule

>>> hdl/sapg_checker.sv
`timescale 1ns / 1ps
module sapg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic busy_res,
	input logic step_level
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_noover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result waits");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_level |-> busy_res) else $error("pulse while idle");
endmodule

bind stepper_accel_pulse_generator_top sapg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.data.status), .busy_res(out_ch.data.busy_res),
	.step_level(out_ch.data.step_level)
);
